### rtl/chained_hash_table_assert.svh
// Assertion macros for the chained hash table
`ifndef CHAINED_HASH_TABLE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;

  localparam int NUM_BUCKETS = 16;
  localparam int NUM_ENTRIES = 32;

  localparam int KEY_W   = 31;
  localparam int VAL_W   = 64;
  localparam int SLOT_W  = $clog2(NUM_ENTRIES);
  localparam int LINK_W  = SLOT_W + 1;
  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int CNT_W   = $clog2(NUM_ENTRIES + 1);
  localparam int KV_W    = KEY_W + VAL_W;
  localparam int OSLOT_W = 5;
  localparam int OCNT_W  = 6;

  localparam logic [LINK_W-1:0] EMPTY = LINK_W'(NUM_ENTRIES);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_WALK   = 9'b000000100,
    S_CMP    = 9'b000001000,
    S_INS_RD = 9'b000010000,
    S_INS_WR = 9'b000100000,
    S_INS_LK = 9'b001000000,
    S_DEL    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

endpackage
`default_nettype wire

### rtl/cht_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cht_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [cht_pkg::KEY_W-1:0]   key;
  logic [cht_pkg::VAL_W-1:0]   value;
  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface cht_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [cht_pkg::OSLOT_W-1:0]  slot_index;
  logic [cht_pkg::VAL_W-1:0]    found_value;
  logic [cht_pkg::OCNT_W-1:0]   entry_count;
  modport source (output valid, status, slot_index, found_value, entry_count, input ready);
  modport sink   (input valid, status, slot_index, found_value, entry_count, output ready);
endinterface
`default_nettype wire

### rtl/cht_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/chained_hash_table.sv
// Chained hash table: insert, delete and search of 31-bit keys with 64-bit values.
// in_ch carries one request per transfer (req_type, key, value); out_ch returns
// exactly one result per request (status, slot_index, found_value, entry_count).
// Requests are served one at a time. A request is taken only while the
// sequencer is idle; the chain of the key's bucket is walked through the entry
// memory at one entry per cycle, comparing at most 32 entries. An unused code
// or an insert into a full table goes straight to the result; a search, a
// delete that misses or a duplicate insert ends with the walk. An insert that
// stores then writes the new entry and links it in; a delete unlinks the hit,
// updating its predecessor first when it is not at the chain head, and then
// pushes its slot onto the free stack.
// The result sits in an output register; while the receiver stalls it holds,
// and the sequencer waits with the next result, taking no new request.
// After reset the link memory is swept to build the free-slot stack;
// in_ch.ready stays low during the sweep. Bucket heads, free stack top and
// record count clear at reset.
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_table_assert.svh"
module chained_hash_table (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cht_req_if.sink    in_ch,
  cht_rsp_if.source  out_ch
);

  localparam int N      = cht_pkg::NUM_ENTRIES;
  localparam int SW     = cht_pkg::SLOT_W;
  localparam int LW     = cht_pkg::LINK_W;
  localparam int CW     = cht_pkg::CNT_W;
  localparam int KW     = cht_pkg::KEY_W;
  localparam int VW     = cht_pkg::VAL_W;

  cht_pkg::state_t state_r, state_nxt;

  logic [LW-1:0] heads_r [cht_pkg::NUM_BUCKETS];
  logic [LW-1:0] head_wdata;
  logic          head_we;

  logic [LW-1:0] free_top_r, free_top_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] init_cnt_r, init_cnt_nxt;

  logic [1:0]                req_r, req_nxt;
  logic [KW-1:0]             key_r, key_nxt;
  logic [VW-1:0]             val_r, val_nxt;
  logic [cht_pkg::BKT_W-1:0] bkt_r, bkt_nxt;
  logic [LW-1:0]             cur_r, cur_nxt;
  logic [LW-1:0]             prev_r, prev_nxt;
  logic [LW-1:0]             hit_link_r, hit_link_nxt;
  logic [CW-1:0]             steps_r, steps_nxt;

  logic [1:0]                    res_status_r, res_status_nxt;
  logic [cht_pkg::OSLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [VW-1:0]                 res_val_r, res_val_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_status_r;
  logic [cht_pkg::OSLOT_W-1:0]   out_slot_r;
  logic [VW-1:0]                 out_val_r;
  logic [cht_pkg::OCNT_W-1:0]    out_cnt_r;
  logic                          out_load;

  logic                     kv_we;
  logic [SW-1:0]            kv_waddr;
  logic [cht_pkg::KV_W-1:0] kv_wdata, kv_rdata;
  logic                     ln_we;
  logic [SW-1:0]            ln_waddr;
  logic [LW-1:0]            ln_wdata, ln_rdata;
  logic [SW-1:0]            raddr;

  logic                      in_xfer;
  logic [cht_pkg::BKT_W-1:0] in_bkt;
  logic                      full;

  cht_ram #(.WIDTH(cht_pkg::KV_W), .DEPTH(N)) u_kv_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (kv_waddr),
    .wdata (kv_wdata),
    .raddr (raddr),
    .rdata (kv_rdata)
  );

  cht_ram #(.WIDTH(LW), .DEPTH(N)) u_link_ram (
    .clk   (clk),
    .we    (ln_we),
    .waddr (ln_waddr),
    .wdata (ln_wdata),
    .raddr (raddr),
    .rdata (ln_rdata)
  );

  assign in_ch.ready = (state_r == cht_pkg::S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_bkt      = cht_pkg::BKT_W'(in_ch.key % cht_pkg::NUM_BUCKETS);
  assign full        = (count_r >= CW'(N)) || (free_top_r >= cht_pkg::EMPTY);
  assign out_load    = (state_r == cht_pkg::S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    free_top_nxt   = free_top_r;
    count_nxt      = count_r;
    init_cnt_nxt   = init_cnt_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    bkt_nxt        = bkt_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    hit_link_nxt   = hit_link_r;
    steps_nxt      = steps_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_val_nxt    = res_val_r;
    head_we        = 1'b0;
    head_wdata     = cur_r;
    kv_we          = 1'b0;
    kv_waddr       = free_top_r[SW-1:0];
    kv_wdata       = {key_r, val_r};
    ln_we          = 1'b0;
    ln_waddr       = init_cnt_r;
    ln_wdata       = cht_pkg::EMPTY;
    raddr          = cur_r[SW-1:0];

    unique case (state_r)
      cht_pkg::S_INIT: begin
        ln_we = 1'b1;
        if (init_cnt_r == SW'(N - 1)) begin
          ln_wdata  = cht_pkg::EMPTY;
          state_nxt = cht_pkg::S_IDLE;
        end else begin
          ln_wdata = LW'(init_cnt_r) + LW'(1);
        end
        init_cnt_nxt = init_cnt_r + SW'(1);
      end

      cht_pkg::S_IDLE: begin
        if (in_xfer) begin
          req_nxt        = in_ch.req_type;
          key_nxt        = in_ch.key;
          val_nxt        = in_ch.value;
          bkt_nxt        = in_bkt;
          cur_nxt        = heads_r[in_bkt];
          prev_nxt       = cht_pkg::EMPTY;
          steps_nxt      = '0;
          res_status_nxt = cht_pkg::ST_MISS;
          res_slot_nxt   = '0;
          res_val_nxt    = '0;
          if (in_ch.req_type == cht_pkg::REQ_NONE) begin
            state_nxt = cht_pkg::S_OUT;
          end else if (in_ch.req_type == cht_pkg::REQ_INSERT && full) begin
            res_status_nxt = cht_pkg::ST_FULL;
            state_nxt      = cht_pkg::S_OUT;
          end else begin
            state_nxt = cht_pkg::S_WALK;
          end
        end
      end

      cht_pkg::S_WALK: begin
        raddr = cur_r[SW-1:0];
        if (cur_r < cht_pkg::EMPTY) begin
          state_nxt = cht_pkg::S_CMP;
        end else if (req_r == cht_pkg::REQ_INSERT) begin
          state_nxt = cht_pkg::S_INS_RD;
        end else begin
          state_nxt = cht_pkg::S_OUT;
        end
      end

      cht_pkg::S_CMP: begin
        raddr = ln_rdata[SW-1:0];
        if (kv_rdata[cht_pkg::KV_W-1:VW] == key_r) begin
          hit_link_nxt = ln_rdata;
          res_slot_nxt = cht_pkg::OSLOT_W'(cur_r);
          unique case (req_r)
            cht_pkg::REQ_INSERT: begin
              res_status_nxt = cht_pkg::ST_DUP;
              res_slot_nxt   = '0;
              state_nxt      = cht_pkg::S_OUT;
            end
            cht_pkg::REQ_DELETE: begin
              state_nxt = cht_pkg::S_DEL;
            end
            default: begin
              res_status_nxt = cht_pkg::ST_OK;
              res_val_nxt    = kv_rdata[VW-1:0];
              state_nxt      = cht_pkg::S_OUT;
            end
          endcase
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = ln_rdata;
          steps_nxt = steps_r + CW'(1);
          if (ln_rdata < cht_pkg::EMPTY && steps_r < CW'(N - 1)) begin
            state_nxt = cht_pkg::S_CMP;
          end else if (req_r == cht_pkg::REQ_INSERT) begin
            state_nxt = cht_pkg::S_INS_RD;
          end else begin
            state_nxt = cht_pkg::S_OUT;
          end
        end
      end

      cht_pkg::S_INS_RD: begin
        raddr     = free_top_r[SW-1:0];
        kv_we     = 1'b1;
        kv_waddr  = free_top_r[SW-1:0];
        cur_nxt   = free_top_r;
        state_nxt = cht_pkg::S_INS_WR;
      end

      cht_pkg::S_INS_WR: begin
        free_top_nxt = ln_rdata;
        ln_we        = 1'b1;
        ln_waddr     = cur_r[SW-1:0];
        ln_wdata     = cht_pkg::EMPTY;
        state_nxt    = cht_pkg::S_INS_LK;
      end

      cht_pkg::S_INS_LK: begin
        if (prev_r < cht_pkg::EMPTY) begin
          ln_we    = 1'b1;
          ln_waddr = prev_r[SW-1:0];
          ln_wdata = cur_r;
        end else begin
          head_we    = 1'b1;
          head_wdata = cur_r;
        end
        count_nxt      = count_r + CW'(1);
        res_status_nxt = cht_pkg::ST_OK;
        res_slot_nxt   = cht_pkg::OSLOT_W'(cur_r);
        state_nxt      = cht_pkg::S_OUT;
      end

      cht_pkg::S_DEL: begin
        if (prev_r < cht_pkg::EMPTY) begin
          ln_we    = 1'b1;
          ln_waddr = prev_r[SW-1:0];
          ln_wdata = hit_link_r;
          prev_nxt = '1;
        end else begin
          if (prev_r == cht_pkg::EMPTY) begin
            head_we    = 1'b1;
            head_wdata = hit_link_r;
          end
          ln_we          = 1'b1;
          ln_waddr       = cur_r[SW-1:0];
          ln_wdata       = free_top_r;
          free_top_nxt   = cur_r;
          if (count_r != '0) begin
            count_nxt = count_r - CW'(1);
          end
          res_status_nxt = cht_pkg::ST_OK;
          state_nxt      = cht_pkg::S_OUT;
        end
      end

      cht_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = cht_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = cht_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cht_pkg::S_INIT;
      free_top_r  <= '0;
      count_r     <= '0;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < cht_pkg::NUM_BUCKETS; i++) begin
        heads_r[i] <= cht_pkg::EMPTY;
      end
    end else begin
      state_r     <= state_nxt;
      free_top_r  <= free_top_nxt;
      count_r     <= count_nxt;
      init_cnt_r  <= init_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_we) begin
        heads_r[bkt_r] <= head_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    bkt_r        <= bkt_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    hit_link_r   <= hit_link_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_val_r    <= res_val_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_val_r    <= res_val_r;
      out_cnt_r    <= cht_pkg::OCNT_W'(count_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot_index  = out_slot_r;
  assign out_ch.found_value = out_val_r;
  assign out_ch.entry_count = out_cnt_r;

  `CHT_ASSERT_IMPL(a_count_range, 1'b1, count_r <= CW'(N), "record count above capacity")
  `CHT_ASSERT_NEXT(a_insert_count, state_r == cht_pkg::S_INS_LK, count_r == $past(count_r) + CW'(1), "insert did not bump count")
  `CHT_ASSERT_IMPL(a_miss_zero, out_valid_r && out_status_r != cht_pkg::ST_OK, out_slot_r == '0 && out_val_r == '0, "refused result carries data")
  `CHT_ASSERT_IMPL(a_walk_bound, state_r == cht_pkg::S_CMP, steps_r < CW'(N), "chain walk overran")

endmodule
`default_nettype wire
